[sv/cfr_pkg.sv]
// Shared constants and types for the command frame responder.
`default_nettype none
package cfr_pkg;

	localparam int MAX_FRAME = 16;
	localparam int MIN_FRAME = 5;
	localparam int AW        = $clog2(MAX_FRAME);
	localparam int CW        = $clog2(MAX_FRAME + 1);

	localparam logic [15:0] BUF_BYTES_RST = 16'd1024;
	localparam logic [6:0]  CMD_MASK      = 7'b1111111;

	localparam logic [6:0] CMD_RATE   = 7'h01;
	localparam logic [6:0] CMD_LENGTH = 7'h02;
	localparam logic [6:0] CMD_STREAM = 7'h03;
	localparam logic [6:0] CMD_COUNT  = 7'h04;
	localparam logic [6:0] CMD_DEPTH  = 7'h06;

	localparam logic [2:0] ST_REPLY   = 3'd0;
	localparam logic [2:0] ST_SUM_ERR = 3'd1;
	localparam logic [2:0] ST_BUSY    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_LOADED  = 3'd4;
	localparam logic [2:0] ST_BAD_LEN = 3'd5;

	typedef enum logic [5:0] {
		S_COLLECT = 6'b000001,
		S_CHECK   = 6'b000010,
		S_DIV     = 6'b000100,
		S_STAT    = 6'b001000,
		S_READ    = 6'b010000,
		S_EMIT    = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		RK_SET,
		RK_RATE,
		RK_LEN,
		RK_STREAM,
		RK_ECHO,
		RK_DEPTH
	} reply_kind_t;

endpackage
`default_nettype wire

[sv/cfr_div.sv]
// Iterative 16 by 8 bit restoring divider, one quotient bit per cycle.
`default_nettype none
module cfr_div import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] quo_q;
	logic [8:0]  rem_q;
	logic [7:0]  dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  trial;

	// shift in the next dividend bit
	assign trial = {rem_q[7:0], quo_q[15]};

	// run one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[sv/command_frame_responder.sv]
// Top level of the command frame responder: frame store, checks and reply sequencer.
`default_nettype none
// Request bytes are written into a 16-entry frame store; at the byte marked last
// the frame is checked (length, pending stream count, 16-bit byte sum against the
// little-endian trailer) and either one status word or a reply frame follows.
// Reply words are read back from the frame store one at a time, each by a memory
// read (S_READ) and then an output load (S_EMIT), as there is a single read port.
// A depth request first runs the bit-serial divider. No request byte is taken while
// a frame is being checked or answered; frame-sent events share that input channel.
// The user writes buffer_bytes through cfg_we/cfg_wdata while idle; not enforced.
module command_frame_responder import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [7:0]  request_byte,
	input  logic        last_byte,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  reply_byte,
	output logic        reply_last,
	output logic [2:0]  status,
	output logic [15:0] sample_rate,
	output logic [7:0]  frame_length,
	output logic [7:0]  stream_enable,
	output logic [7:0]  frames_left
);

	logic [7:0]  mem [MAX_FRAME];
	logic [7:0]  rd_q;

	state_t      state_q;
	reply_kind_t kind_q;
	logic [15:0] buf_bytes_q;
	logic [CW-1:0] cnt_q;
	logic        ov_q;
	logic [15:0] sum_q;
	logic [7:0]  last1_q, last2_q, b1_q, b3_q, b4_q;
	logic [15:0] rate_q;
	logic [7:0]  len_q, stream_q, pend_q;
	logic [2:0]  stat_q;
	logic [CW-1:0] rlen_q, idx_q;
	logic [15:0] rsum_q, depth_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [2:0]  out_stat_q;
	logic [15:0] out_rate_q;
	logic [7:0]  out_len_q, out_stream_q, out_pend_q;

	logic        accept, out_free, div_start, div_done, load_out;
	logic [15:0] div_quo, body_sum;
	logic [6:0]  cmd;
	logic        is_get;
	logic [7:0]  body_byte, emit_byte;
	logic        in_body, emit_last;

	state_t        chk_state;
	reply_kind_t   chk_kind;
	logic [CW-1:0] chk_rlen;
	logic [2:0]    chk_stat;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_COLLECT);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign load_out  = (state_q == S_STAT || state_q == S_EMIT) && out_free;
	assign cmd       = b1_q[6:0] & CMD_MASK;
	assign is_get    = b1_q[7];
	assign body_sum  = sum_q - {8'd0, last1_q} - {8'd0, last2_q};
	assign div_start = (state_q == S_CHECK) && (chk_state == S_DIV);

	cfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (buf_bytes_q),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// write request bytes, read reply bytes
	always_ff @(posedge clk) begin
		if (accept && !action && (cnt_q < CW'(MAX_FRAME)))
			mem[cnt_q[AW-1:0]] <= request_byte;
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// pick the outcome of a finished frame
	always_comb begin
		chk_state = S_STAT;
		chk_kind  = RK_ECHO;
		chk_rlen  = cnt_q;
		chk_stat  = ST_REPLY;
		if (ov_q || cnt_q < CW'(MIN_FRAME)) begin
			chk_stat = ST_BAD_LEN;
		end else if (pend_q != 8'd0) begin
			chk_stat = ST_BUSY;
		end else if (body_sum != {last1_q, last2_q}) begin
			chk_stat = ST_SUM_ERR;
		end else begin
			chk_state = S_READ;
			case (cmd)
				CMD_RATE: begin
					chk_kind = is_get ? RK_RATE : RK_SET;
					chk_rlen = is_get ? CW'(7) : CW'(5);
				end
				CMD_LENGTH: begin
					chk_kind = is_get ? RK_LEN : RK_SET;
					chk_rlen = is_get ? CW'(6) : CW'(5);
				end
				CMD_STREAM: begin
					chk_kind = is_get ? RK_STREAM : RK_SET;
					chk_rlen = is_get ? CW'(6) : CW'(5);
				end
				CMD_COUNT: begin
					if (!is_get) begin
						chk_stat  = ST_LOADED;
						chk_state = S_STAT;
					end
				end
				CMD_DEPTH: begin
					if (is_get) begin
						chk_kind  = RK_DEPTH;
						chk_rlen  = CW'(7);
						chk_state = S_DIV;
					end
				end
				default: begin
					chk_stat  = ST_UNKNOWN;
					chk_state = S_STAT;
				end
			endcase
		end
	end

	// substitute reply fields over the echoed bytes
	always_comb begin
		body_byte = rd_q;
		if (idx_q == CW'(2)) begin
			case (kind_q)
				RK_SET:    body_byte = 8'd0;
				RK_RATE:   body_byte = 8'd2;
				RK_LEN:    body_byte = 8'd1;
				RK_STREAM: body_byte = 8'd1;
				default:   body_byte = rd_q;
			endcase
		end else if (idx_q == CW'(3)) begin
			case (kind_q)
				RK_RATE:   body_byte = rate_q[15:8];
				RK_LEN:    body_byte = len_q;
				RK_STREAM: body_byte = stream_q;
				RK_DEPTH:  body_byte = depth_q[15:8];
				default:   body_byte = rd_q;
			endcase
		end else if (idx_q == CW'(4)) begin
			case (kind_q)
				RK_RATE:  body_byte = rate_q[7:0];
				RK_DEPTH: body_byte = depth_q[7:0];
				default:  body_byte = rd_q;
			endcase
		end
		in_body   = (idx_q < rlen_q - CW'(2));
		emit_last = (idx_q == rlen_q - CW'(1));
		if (in_body)
			emit_byte = body_byte;
		else if (idx_q == rlen_q - CW'(2))
			emit_byte = rsum_q[15:8];
		else
			emit_byte = rsum_q[7:0];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			buf_bytes_q <= BUF_BYTES_RST;
			cnt_q       <= '0;
			ov_q        <= 1'b0;
			sum_q       <= '0;
			rate_q      <= '0;
			len_q       <= '0;
			stream_q    <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_stat_q  <= ST_REPLY;
			kind_q      <= RK_SET;
			stat_q      <= ST_REPLY;
			rlen_q      <= '0;
			idx_q       <= '0;
			rsum_q      <= '0;
			depth_q     <= '0;
		end else begin
			if (cfg_we)
				buf_bytes_q <= cfg_wdata;
			// load a new word or drop the accepted one
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_COLLECT: begin
					if (accept && action) begin
						if (pend_q != 8'd0)
							pend_q <= pend_q - 8'd1;
					end else if (accept) begin
						if (cnt_q < CW'(MAX_FRAME)) begin
							cnt_q <= cnt_q + CW'(1);
							sum_q <= sum_q + {8'd0, request_byte};
						end else begin
							ov_q <= 1'b1;
						end
						if (last_byte)
							state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// drop the frame state, take the outcome
					cnt_q   <= '0;
					ov_q    <= 1'b0;
					sum_q   <= '0;
					rlen_q  <= chk_rlen;
					state_q <= chk_state;
					kind_q  <= chk_kind;
					stat_q  <= chk_stat;
					if (chk_state == S_READ && !is_get) begin
						case (cmd)
							CMD_RATE:   rate_q   <= {b3_q, b4_q};
							CMD_LENGTH: len_q    <= b3_q;
							CMD_STREAM: stream_q <= b3_q;
							default: ;
						endcase
					end
					if (chk_stat == ST_LOADED)
						pend_q <= b3_q;
					idx_q  <= '0;
					rsum_q <= '0;
				end
				S_DIV: begin
					if (len_q == 8'd0) begin
						depth_q <= '0;
						state_q <= S_READ;
					end else if (div_done) begin
						depth_q <= div_quo;
						state_q <= S_READ;
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_byte_q <= 8'd0;
						out_last_q <= 1'b1;
						out_stat_q <= stat_q;
						state_q    <= S_COLLECT;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_byte_q <= emit_byte;
						out_last_q <= emit_last;
						out_stat_q <= ST_REPLY;
						if (in_body)
							rsum_q <= rsum_q + {8'd0, body_byte};
						idx_q   <= idx_q + CW'(1);
						state_q <= emit_last ? S_COLLECT : S_READ;
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	// capture the bytes that carry command fields and the trailer
	always_ff @(posedge clk) begin
		if (state_q == S_COLLECT && accept && !action && (cnt_q < CW'(MAX_FRAME))) begin
			last2_q <= last1_q;
			last1_q <= request_byte;
			if (cnt_q == CW'(1)) b1_q <= request_byte;
			if (cnt_q == CW'(3)) b3_q <= request_byte;
			if (cnt_q == CW'(4)) b4_q <= request_byte;
		end
	end

	// snapshot settings with each output word
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rate_q   <= rate_q;
			out_len_q    <= len_q;
			out_stream_q <= stream_q;
			out_pend_q   <= pend_q;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign reply_byte    = out_byte_q;
	assign reply_last    = out_last_q;
	assign status        = out_stat_q;
	assign sample_rate   = out_rate_q;
	assign frame_length  = out_len_q;
	assign stream_enable = out_stream_q;
	assign frames_left   = out_pend_q;

endmodule
`default_nettype wire

[sv/cfr_checker.sv]
// Port-level checks for the command frame responder, bound to the top level.
`default_nettype none
module cfr_checker import cfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] reply_byte,
	input logic       reply_last,
	input logic [2:0] status
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(reply_byte) && $stable(status))
		else $error("stalled reply word changed");

	// a status word is a single empty word
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_REPLY |-> reply_last && reply_byte == 8'd0)
		else $error("status word malformed");

	// no request byte is taken in the middle of a reply
	a_midreply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !reply_last |-> req_stall)
		else $error("input open during reply");

endmodule

bind command_frame_responder cfr_checker u_cfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.reply_byte (reply_byte),
	.reply_last (reply_last),
	.status     (status)
);
`default_nettype wire
